[sv/pts_pkg.sv]
// Package of the process table scheduler: codes, state type and slot record.
`timescale 1ns / 1ps
package pts_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    localparam logic [2:0] LS_UNUSED   = 3'd0;
    localparam logic [2:0] LS_SLEEPING = 3'd2;
    localparam logic [2:0] LS_RUNNABLE = 3'd3;
    localparam logic [2:0] LS_RUNNING  = 3'd4;
    localparam logic [2:0] LS_ZOMBIE   = 3'd5;

    localparam logic [2:0] CODE_OK             = 3'd0;
    localparam logic [2:0] CODE_NO_CURRENT     = 3'd1;
    localparam logic [2:0] CODE_FULL           = 3'd2;
    localparam logic [2:0] CODE_NO_CHILDREN    = 3'd3;
    localparam logic [2:0] CODE_NOT_FOUND      = 3'd4;
    localparam logic [2:0] CODE_CHILDREN_ALIVE = 3'd5;

    localparam logic [2:0] ACT_ALLOC    = 3'd0;
    localparam logic [2:0] ACT_FORK     = 3'd1;
    localparam logic [2:0] ACT_EXIT     = 3'd2;
    localparam logic [2:0] ACT_WAIT     = 3'd3;
    localparam logic [2:0] ACT_KILL     = 3'd4;
    localparam logic [2:0] ACT_SLEEP    = 3'd5;
    localparam logic [2:0] ACT_WAKEUP   = 3'd6;
    localparam logic [2:0] ACT_SCHEDULE = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE_RD,
        S_PRE_WR,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  life;
        logic [15:0] id;
        logic [15:0] parent;
        logic        kill;
        logic [31:0] xcode;
        logic [31:0] chan;
    } t_rec;

endpackage

[sv/pts_if.sv]
// Handshake interfaces for the action and result channels.
`timescale 1ns / 1ps
interface pts_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [15:0]        target_pid;
    logic [31:0]        channel;
    logic signed [31:0] exit_code;
    modport source (output valid, action, target_pid, channel, exit_code, input ready);
    modport sink (input valid, action, target_pid, channel, exit_code, output ready);
endinterface

interface pts_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         code;
    logic [15:0]        result_pid;
    logic signed [31:0] reaped_status;
    logic [15:0]        current_pid;
    logic               current_killed;
    modport source (output valid, code, result_pid, reaped_status, current_pid,
                    current_killed, input ready);
    modport sink (input valid, code, result_pid, reaped_status, current_pid,
                  current_killed, output ready);
endinterface

[sv/process_table_scheduler.sv]
// Process table scheduler: slot table in one memory, one slot examined per cycle.
// An action refused for lack of a running task goes straight to the result; alloc,
// fork, wait, kill and wakeup scan up to NUM_SLOTS slots; exit, sleep and schedule
// first read-modify-write the running slot, if any, then scan. One action at a time,
// set by the single read port of the slot memory. Result sits in an output register.
// Reset: synchronous; per-slot valid bits clear the table, no sweep.
`timescale 1ns / 1ps
module process_table_scheduler #(
    parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pts_in_if.sink    i_in,
    pts_out_if.source o_out
);
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = SW + 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);

    pts_pkg::t_rec   r_mem [NUM_SLOTS];
    logic            r_vld [NUM_SLOTS];
    pts_pkg::t_rec   r_rd;
    logic            r_rdv;
    pts_pkg::t_rec   rec;
    logic [SW-1:0]   rd_addr;
    logic            mem_we;
    logic [SW-1:0]   mem_wa;
    pts_pkg::t_rec   mem_wd;

    pts_pkg::t_state r_state, n_state;
    logic [2:0]      r_act, n_act;
    logic [15:0]     r_tgt, n_tgt;
    logic [31:0]     r_chan, n_chan;
    logic [31:0]     r_xc, n_xc;
    logic [SW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_pv, n_pv;
    logic [SW-1:0]   r_pidx, n_pidx;
    logic            r_have, n_have;
    logic [15:0]     r_nid, n_nid;
    logic [SW-1:0]   r_run, n_run;
    logic            r_run_v, n_run_v;
    logic [SW-1:0]   r_last, n_last;
    logic [15:0]     r_cur_id, n_cur_id;
    logic            r_cur_kill, n_cur_kill;
    logic [2:0]      r_code, n_code;
    logic [15:0]     r_rpid, n_rpid;
    logic [31:0]     r_rstat, n_rstat;
    logic            r_ov, n_ov;
    logic [2:0]      r_ocode, n_ocode;
    logic [15:0]     r_orpid, n_orpid;
    logic [31:0]     r_orstat, n_orstat;
    logic [15:0]     r_ocpid, n_ocpid;
    logic            r_ockill, n_ockill;

    logic            hit;
    logic            exhausted;
    logic            accept;
    logic            need_cur;
    logic            resched;
    logic            out_free;

    assign rec       = r_rdv ? r_rd : '0;
    assign accept    = i_in.valid && i_in.ready;
    assign out_free  = !r_ov || o_out.ready;
    assign exhausted = (r_state == pts_pkg::S_SCAN) && !r_pv && (r_cnt == CW'(NUM_SLOTS));
    assign need_cur  = (i_in.action == pts_pkg::ACT_FORK) || (i_in.action == pts_pkg::ACT_EXIT)
                    || (i_in.action == pts_pkg::ACT_WAIT) || (i_in.action == pts_pkg::ACT_SLEEP);
    assign resched   = (i_in.action == pts_pkg::ACT_EXIT) || (i_in.action == pts_pkg::ACT_SLEEP)
                    || (i_in.action == pts_pkg::ACT_SCHEDULE);

    assign i_in.ready           = (r_state == pts_pkg::S_IDLE);
    assign o_out.valid          = r_ov;
    assign o_out.code           = r_ocode;
    assign o_out.result_pid     = r_orpid;
    assign o_out.reaped_status  = r_orstat;
    assign o_out.current_pid    = r_ocpid;
    assign o_out.current_killed = r_ockill;

    always_comb begin
        hit = 1'b0;
        if (r_state == pts_pkg::S_SCAN && r_pv) begin
            case (r_act)
                pts_pkg::ACT_ALLOC, pts_pkg::ACT_FORK: hit = (rec.life == pts_pkg::LS_UNUSED);
                pts_pkg::ACT_WAIT: hit = (rec.life == pts_pkg::LS_ZOMBIE)
                                       && (rec.parent == r_cur_id);
                pts_pkg::ACT_KILL: hit = (rec.life != pts_pkg::LS_UNUSED) && (rec.id == r_tgt);
                pts_pkg::ACT_WAKEUP: hit = 1'b0;
                default: hit = (rec.life == pts_pkg::LS_RUNNABLE);
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pts_pkg::S_IDLE: begin
                if (accept) begin
                    if (need_cur && !r_run_v) begin
                        n_state = pts_pkg::S_DONE;
                    end else if (resched && r_run_v) begin
                        n_state = pts_pkg::S_PRE_RD;
                    end else begin
                        n_state = pts_pkg::S_SCAN;
                    end
                end
            end
            pts_pkg::S_PRE_RD: n_state = pts_pkg::S_PRE_WR;
            pts_pkg::S_PRE_WR: n_state = pts_pkg::S_SCAN;
            pts_pkg::S_SCAN: begin
                if (hit || exhausted) begin
                    n_state = pts_pkg::S_DONE;
                end
            end
            pts_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = pts_pkg::S_IDLE;
                end
            end
            default: n_state = pts_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_act      = r_act;
        n_tgt      = r_tgt;
        n_chan     = r_chan;
        n_xc       = r_xc;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_pv       = 1'b0;
        n_pidx     = r_pidx;
        n_have     = r_have;
        n_nid      = r_nid;
        n_run      = r_run;
        n_run_v    = r_run_v;
        n_last     = r_last;
        n_cur_id   = r_cur_id;
        n_cur_kill = r_cur_kill;
        n_code     = r_code;
        n_rpid     = r_rpid;
        n_rstat    = r_rstat;
        n_ov       = r_ov && !o_out.ready;
        n_ocode    = r_ocode;
        n_orpid    = r_orpid;
        n_orstat   = r_orstat;
        n_ocpid    = r_ocpid;
        n_ockill   = r_ockill;
        rd_addr    = r_run;
        mem_we     = 1'b0;
        mem_wa     = r_pidx;
        mem_wd     = rec;
        case (r_state)
            pts_pkg::S_IDLE: begin
                if (accept) begin
                    n_act   = i_in.action;
                    n_tgt   = i_in.target_pid;
                    n_chan  = i_in.channel;
                    n_xc    = i_in.exit_code;
                    n_cnt   = '0;
                    n_have  = 1'b0;
                    n_code  = (need_cur && !r_run_v) ? pts_pkg::CODE_NO_CURRENT
                                                     : pts_pkg::CODE_OK;
                    n_rpid  = '0;
                    n_rstat = '0;
                    n_idx   = resched ? ((r_last == LAST_IDX) ? '0 : r_last + 1'b1) : '0;
                end
            end
            pts_pkg::S_PRE_WR: begin
                mem_we = 1'b1;
                mem_wa = r_run;
                case (r_act)
                    pts_pkg::ACT_EXIT: begin
                        mem_wd.life  = pts_pkg::LS_ZOMBIE;
                        mem_wd.xcode = r_xc;
                    end
                    pts_pkg::ACT_SLEEP: begin
                        mem_wd.life = pts_pkg::LS_SLEEPING;
                        mem_wd.chan = r_chan;
                    end
                    default: mem_wd.life = pts_pkg::LS_RUNNABLE;
                endcase
            end
            pts_pkg::S_SCAN: begin
                rd_addr = r_idx;
                if (r_cnt != CW'(NUM_SLOTS)) begin
                    n_pv   = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                end
                if (r_pv && r_act == pts_pkg::ACT_WAIT && rec.life != pts_pkg::LS_UNUSED
                        && rec.parent == r_cur_id) begin
                    n_have = 1'b1;
                end
                if (r_pv && r_act == pts_pkg::ACT_WAKEUP && rec.life == pts_pkg::LS_SLEEPING
                        && rec.chan == r_chan) begin
                    mem_we      = 1'b1;
                    mem_wd.life = pts_pkg::LS_RUNNABLE;
                    mem_wd.chan = '0;
                end
                if (hit) begin
                    mem_we = 1'b1;
                    case (r_act)
                        pts_pkg::ACT_ALLOC, pts_pkg::ACT_FORK: begin
                            mem_wd.life   = pts_pkg::LS_RUNNABLE;
                            mem_wd.id     = r_nid;
                            mem_wd.parent = (r_act == pts_pkg::ACT_FORK) ? r_cur_id : '0;
                            mem_wd.kill   = 1'b0;
                            mem_wd.xcode  = '0;
                            mem_wd.chan   = '0;
                            n_rpid        = r_nid;
                            n_nid         = (r_nid == 16'hFFFF) ? 16'd1 : r_nid + 16'd1;
                        end
                        pts_pkg::ACT_WAIT: begin
                            mem_wd.life = pts_pkg::LS_UNUSED;
                            mem_wd.id   = '0;
                            n_rpid      = rec.id;
                            n_rstat     = rec.xcode;
                        end
                        pts_pkg::ACT_KILL: begin
                            mem_wd.kill = 1'b1;
                            if (rec.life == pts_pkg::LS_SLEEPING) begin
                                mem_wd.life = pts_pkg::LS_RUNNABLE;
                            end
                            if (r_run_v && r_pidx == r_run) begin
                                n_cur_kill = 1'b1;
                            end
                        end
                        default: begin
                            mem_wd.life = pts_pkg::LS_RUNNING;
                            n_run       = r_pidx;
                            n_last      = r_pidx;
                            n_run_v     = 1'b1;
                            n_cur_id    = rec.id;
                            n_cur_kill  = rec.kill;
                        end
                    endcase
                end else if (exhausted) begin
                    case (r_act)
                        pts_pkg::ACT_ALLOC, pts_pkg::ACT_FORK: n_code = pts_pkg::CODE_FULL;
                        pts_pkg::ACT_WAIT: n_code = r_have ? pts_pkg::CODE_CHILDREN_ALIVE
                                                           : pts_pkg::CODE_NO_CHILDREN;
                        pts_pkg::ACT_KILL: n_code = pts_pkg::CODE_NOT_FOUND;
                        pts_pkg::ACT_WAKEUP: n_code = pts_pkg::CODE_OK;
                        default: n_run_v = 1'b0;
                    endcase
                end
            end
            pts_pkg::S_DONE: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_ocode  = r_code;
                    n_orpid  = r_rpid;
                    n_orstat = r_rstat;
                    n_ocpid  = r_run_v ? r_cur_id : '0;
                    n_ockill = r_run_v && r_cur_kill;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd  <= r_mem[rd_addr];
        r_rdv <= r_vld[rd_addr];
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (mem_we && mem_wa == SW'(k)) begin
                r_vld[k] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pts_pkg::S_IDLE;
            r_pv       <= 1'b0;
            r_nid      <= 16'd1;
            r_run      <= '0;
            r_run_v    <= 1'b0;
            r_last     <= '0;
            r_cur_id   <= '0;
            r_cur_kill <= 1'b0;
            r_ov       <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_pv       <= n_pv;
            r_nid      <= n_nid;
            r_run      <= n_run;
            r_run_v    <= n_run_v;
            r_last     <= n_last;
            r_cur_id   <= n_cur_id;
            r_cur_kill <= n_cur_kill;
            r_ov       <= n_ov;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_tgt    <= n_tgt;
        r_chan   <= n_chan;
        r_xc     <= n_xc;
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_have   <= n_have;
        r_code   <= n_code;
        r_rpid   <= n_rpid;
        r_rstat  <= n_rstat;
        r_ocode  <= n_ocode;
        r_orpid  <= n_orpid;
        r_orstat <= n_orstat;
        r_ocpid  <= n_ocpid;
        r_ockill <= n_ockill;
    end

    a_we_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == pts_pkg::S_PRE_WR || r_state == pts_pkg::S_SCAN))
        else $error("slot write outside a write phase");
    a_run_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_v |-> r_vld[r_run])
        else $error("running slot never written");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(NUM_SLOTS))
        else $error("scan count past table depth");
    a_nid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nid != 16'd0)
        else $error("next id is zero");
endmodule
